// ===== rtl/bpta_pkg.sv =====
// Package for the button poll tick event aggregator.
// Holds field widths, function codes, flag positions, register indexes and the result struct.
// No dependencies.
package bpta_pkg;

  localparam int FUNC_W    = 2;
  localparam int PINS_W    = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 8;
  localparam int MS_W      = 16;
  localparam int PROD_W    = 2 * CFG_W;

  localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RADIO = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDER  = 8'd1;

  localparam int FLAG_BUTTONS = 0;
  localparam int FLAG_TIMER   = 1;
  localparam int FLAG_RADIO   = 2;
  localparam int FLAGS_W      = 3;

  localparam logic [MS_W-1:0]  MS_MAX        = 16'hFFFF;
  localparam logic [CFG_W-1:0] CFG_RESET_VAL = 8'd1;

  typedef struct packed {
    logic              wake;
    logic              event_buttons;
    logic              event_timer;
    logic              event_radio;
    logic [MS_W-1:0]   elapsed_ms;
    logic [PINS_W-1:0] buttons;
  } result_t;

endpackage

// ===== rtl/bpta_cmd_if.sv =====
// Command channel of the aggregator: function code and raw button pins.
// Depends on bpta_pkg.
interface bpta_cmd_if;
  import bpta_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PINS_W-1:0] pins_raw;

  modport source (output valid, output func, output pins_raw, input ready);
  modport sink   (input valid, input func, input pins_raw, output ready);
endinterface

// ===== rtl/bpta_rsp_if.sv =====
// Result channel of the aggregator: wake, event flags, elapsed time and buttons.
// Depends on bpta_pkg.
interface bpta_rsp_if;
  import bpta_pkg::*;

  logic              valid;
  logic              ready;
  logic              wake;
  logic              event_buttons;
  logic              event_timer;
  logic              event_radio;
  logic [MS_W-1:0]   elapsed_ms;
  logic [PINS_W-1:0] buttons;

  modport source (output valid, output wake, output event_buttons, output event_timer,
                  output event_radio, output elapsed_ms, output buttons, input ready);
  modport sink   (input valid, input wake, input event_buttons, input event_timer,
                  input event_radio, input elapsed_ms, input buttons, output ready);
endinterface

// ===== rtl/bpta_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on bpta_pkg.
interface bpta_cfg_if;
  import bpta_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/button_poll_tick_event_aggregator.sv =====
// Button poll tick event aggregator, top level.
// Depends on bpta_pkg, bpta_cmd_if, bpta_rsp_if and bpta_cfg_if.
//
// Takes one command word per clock unless rsp.ready stalls, and returns exactly one result
// word for each: the word is captured in an input register, processed by a single pass
// of compare, decrement and saturating add against the block state, and stored in a result
// register. The product poll_interval * tick_divider is kept in a register refreshed on each
// configuration write, so the timer path is only one 16-bit add. cmd.ready stays high while
// the result register is empty or being taken, so a full stream runs at one word per cycle.
// Configuration writes are always accepted and take effect at the next clock.
module button_poll_tick_event_aggregator (
  input logic        clk,
  input logic        rst,
  bpta_cmd_if.sink   cmd,
  bpta_rsp_if.source rsp,
  bpta_cfg_if.sink   cfg
);
  import bpta_pkg::*;

  logic [CFG_W-1:0]   poll_interval;
  logic [CFG_W-1:0]   tick_divider;
  logic [PROD_W-1:0]  ms_step;

  logic [PINS_W-1:0]  last_pressed, last_pressed_next;
  logic [CFG_W-1:0]   div_count, div_count_next;
  logic [MS_W-1:0]    ms_accum, ms_accum_next;
  logic [FLAGS_W-1:0] pending, pending_next;

  logic               stg_valid;
  logic [FUNC_W-1:0]  stg_func;
  logic [PINS_W-1:0]  stg_pins;

  logic               out_valid;
  result_t            result, result_next;

  logic               advance;
  logic               cmd_take;
  logic               cfg_take;
  logic [PINS_W-1:0]  pressed;
  logic [MS_W:0]      sum;

  assign advance   = !out_valid || rsp.ready;
  assign cmd.ready = !stg_valid || advance;
  assign cmd_take  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign cfg_take  = cfg.valid;

  assign pressed = ~stg_pins;
  assign sum     = {1'b0, ms_accum} + {1'b0, ms_step};

  always_comb begin
    result_next       = '0;
    last_pressed_next = last_pressed;
    div_count_next    = div_count;
    ms_accum_next     = ms_accum;
    pending_next      = pending;
    unique case (stg_func)
      FUNC_POLL: begin
        if (pressed != last_pressed) begin
          last_pressed_next          = pressed;
          pending_next[FLAG_BUTTONS] = 1'b1;
          result_next.wake           = 1'b1;
        end
        if (div_count <= CFG_W'(1)) begin
          div_count_next           = tick_divider;
          ms_accum_next            = sum[MS_W] ? MS_MAX : sum[MS_W-1:0];
          pending_next[FLAG_TIMER] = 1'b1;
          result_next.wake         = 1'b1;
        end else begin
          div_count_next = div_count - CFG_W'(1);
        end
      end
      FUNC_RADIO: begin
        pending_next[FLAG_RADIO] = 1'b1;
        result_next.wake         = 1'b1;
      end
      FUNC_FETCH: begin
        result_next.event_buttons = pending[FLAG_BUTTONS];
        result_next.event_timer   = pending[FLAG_TIMER];
        result_next.event_radio   = pending[FLAG_RADIO];
        result_next.elapsed_ms    = ms_accum;
        result_next.buttons       = last_pressed;
        pending_next              = '0;
        ms_accum_next             = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid     <= 1'b0;
      out_valid     <= 1'b0;
      poll_interval <= CFG_RESET_VAL;
      tick_divider  <= CFG_RESET_VAL;
      ms_step       <= PROD_W'(CFG_RESET_VAL) * PROD_W'(CFG_RESET_VAL);
      last_pressed  <= '0;
      div_count     <= CFG_RESET_VAL;
      ms_accum      <= '0;
      pending       <= '0;
    end else begin
      if (cmd_take) begin
        stg_valid <= 1'b1;
      end else if (advance) begin
        stg_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= stg_valid;
        if (stg_valid) begin
          last_pressed <= last_pressed_next;
          div_count    <= div_count_next;
          ms_accum     <= ms_accum_next;
          pending      <= pending_next;
        end
      end
      if (cfg_take) begin
        if (cfg.index == REG_POLL_INTERVAL) begin
          poll_interval <= cfg.data;
          ms_step       <= PROD_W'(cfg.data) * PROD_W'(tick_divider);
        end else if (cfg.index == REG_TICK_DIVIDER) begin
          tick_divider <= cfg.data;
          ms_step      <= PROD_W'(poll_interval) * PROD_W'(cfg.data);
          div_count    <= cfg.data;
          ms_accum     <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      stg_func <= cmd.func;
      stg_pins <= cmd.pins_raw;
    end
    if (advance && stg_valid) begin
      result <= result_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.wake          = result.wake;
  assign rsp.event_buttons = result.event_buttons;
  assign rsp.event_timer   = result.event_timer;
  assign rsp.event_radio   = result.event_radio;
  assign rsp.elapsed_ms    = result.elapsed_ms;
  assign rsp.buttons       = result.buttons;

  // fetch clears pending flags and the accumulator
  a_fetch_clears: assert property (@(posedge clk) disable iff (rst)
    advance && stg_valid && stg_func == FUNC_FETCH |=> pending == '0 && ms_accum == '0)
    else $error("fetch did not clear pending state");

  // a result with event flags never also signals wake
  a_fetch_no_wake: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.event_buttons || rsp.event_timer || rsp.event_radio) |-> !rsp.wake)
    else $error("wake set on a fetch result");

  // divider count never runs above the reload value
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    div_count <= tick_divider)
    else $error("divider count above reload value");

  // timer flag always set after a poll whose divider expired
  a_timer_flag: assert property (@(posedge clk) disable iff (rst)
    advance && stg_valid && stg_func == FUNC_POLL && div_count <= CFG_W'(1) && !cfg_take
    |=> pending[FLAG_TIMER])
    else $error("timer flag missing after divider expiry");

endmodule
